// File: design/chip_command_framer_checker_assert.svh
// Assertion macros for the chip command framer and checker.
// Included by design files that carry concurrent assertions; no other dependencies.
`ifndef CHIP_COMMAND_FRAMER_CHECKER_ASSERT_SVH
`define CHIP_COMMAND_FRAMER_CHECKER_ASSERT_SVH

`ifndef SYNTH
`define CCFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccfc assertion failed");
`define CCFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccfc assertion failed");
`else
`define CCFC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CCFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: design/ccfc_pkg.sv
// Types, codes, frame constants and the frame check byte (XOR of the body bytes) for
// the chip command framer and checker. No dependencies.
package ccfc_pkg;

  localparam int unsigned OP_W        = 3;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned REF_W       = 20;
  localparam int unsigned ADDR_W      = 8;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned BITS_W      = 6;
  localparam int unsigned RESP_W      = 48;
  localparam int unsigned WORD_W      = 56;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned CHIP_ID_W   = 5;
  localparam int unsigned SEQ_W       = 3;
  localparam int unsigned TIMEOUT_W   = 10;
  localparam int unsigned BODY_W      = 48;
  localparam int unsigned CRC_W       = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam int unsigned PREAMBLE_FRAMES_DEF = 20;

  typedef enum logic [OP_W-1:0] {
    OP_SETID     = 3'd0,
    OP_WRITE     = 3'd1,
    OP_READ      = 3'd2,
    OP_READNEXT  = 3'd3,
    OP_RESPONSE  = 3'd4,
    OP_TICK      = 3'd5,
    OP_SEQ_RESET = 3'd6,
    OP_NONE      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    PEND_NONE     = 3'd0,
    PEND_SETID    = 3'd1,
    PEND_WRITE    = 3'd2,
    PEND_READ     = 3'd3,
    PEND_READNEXT = 3'd4
  } pend_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK              = 3'd0,
    ST_TIMEOUT         = 3'd1,
    ST_BAD_LENGTH      = 3'd2,
    ST_BAD_ADDRESS     = 3'd3,
    ST_BAD_SEQ         = 3'd4,
    ST_BAD_ID          = 3'd5,
    ST_NOTHING_PENDING = 3'd6
  } status_t;

  localparam logic [MODE_W-1:0] MODE_EFUSE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PADS  = 2'd1;

  localparam logic CFG_KIND_FRAME   = 1'b0;
  localparam logic CFG_KIND_VERDICT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_CHECK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd100;

  localparam logic [2:0] CMD_SETID    = 3'b110;
  localparam logic [2:0] CMD_WRITE    = 3'b111;
  localparam logic [2:0] CMD_READ     = 3'b101;
  localparam logic [2:0] CMD_READNEXT = 3'b100;
  localparam logic [2:0] FILL3        = 3'b111;
  localparam logic [3:0] FILL4        = 4'b1111;
  localparam logic [4:0] FILL5        = 5'b11111;
  localparam logic [REF_W-1:0] REF_ONES = 20'hFFFFF;

  localparam logic [WORD_W-1:0] PREAMBLE_WORD = 56'h3_FFFF_FFFF_FFFF;

  localparam logic [LEN_W-1:0] LEN_PREAMBLE = 6'd50;
  localparam logic [LEN_W-1:0] LEN_LONG     = 6'd56;
  localparam logic [LEN_W-1:0] LEN_READ     = 6'd16;
  localparam logic [LEN_W-1:0] LEN_READNEXT = 6'd8;

  localparam logic [BITS_W-1:0] RESP_SHORT_BITS = 6'd8;
  localparam logic [BITS_W-1:0] RESP_LONG_BITS  = 6'd48;

  function automatic logic [CRC_W-1:0] crc8(input logic [BODY_W-1:0] body);
    logic [CRC_W-1:0] c;
    c = '0;
    for (int i = 0; i < BODY_W / CRC_W; i++) begin
      c = c ^ body[CRC_W*i +: CRC_W];
    end
    return c;
  endfunction

endpackage

// File: design/ccfc_if.sv
// Valid/ready channel interfaces for command/response items and result items.
// Depends on ccfc_pkg for field widths.
interface ccfc_in_if import ccfc_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [MODE_W-1:0]   id_mode;
  logic [REF_W-1:0]    ref_id;
  logic [ADDR_W-1:0]   reg_address;
  logic [DATA_W-1:0]   write_value;
  logic [BITS_W-1:0]   resp_bits;
  logic [RESP_W-1:0]   resp_word;

  modport source (output valid, operation, id_mode, ref_id, reg_address, write_value,
                  resp_bits, resp_word, input ready);
  modport sink (input valid, operation, id_mode, ref_id, reg_address, write_value,
                resp_bits, resp_word, output ready);
endinterface

interface ccfc_out_if import ccfc_pkg::*; ;
  logic                valid;
  logic                ready;
  logic                item_kind;
  logic [WORD_W-1:0]   frame_word;
  logic [LEN_W-1:0]    frame_length;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   read_value;
  logic                last;

  modport source (output valid, item_kind, frame_word, frame_length, status, read_value,
                  last, input ready);
  modport sink (input valid, item_kind, frame_word, frame_length, status, read_value,
                last, output ready);
endinterface

// File: design/chip_command_framer_checker.sv
// Top level of the chip command framer and checker: input register, framing and
// reply checks, output register. Depends on ccfc_pkg, ccfc_if and the assert header.

// Accepts one transaction per cycle unless the output stalls or a setid is still
// streaming; each is loaded into the input register, its result into the output
// register, and a stalled output holds the transaction in the input register.
// Write, read, readnext and response transactions give one result each, a tick one
// on a timeout; reset-sequence, other ticks and unused operation codes give none.
// A setid holds the input register while its PREAMBLE_FRAMES all-ones preamble
// frames and then the setid frame stream through the output register, one frame per
// cycle unless it stalls; that register sets the rate. The user writes configuration
// through cfg_we/cfg_index/cfg_wdata only while idle; the block does not check it.
`include "chip_command_framer_checker_assert.svh"

module chip_command_framer_checker import ccfc_pkg::*; #(
  parameter int unsigned PREAMBLE_FRAMES = PREAMBLE_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ccfc_in_if.sink               in_ch,
  ccfc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned PRE_CNT_W = $clog2(PREAMBLE_FRAMES + 1);
  localparam logic [PRE_CNT_W-1:0] PRE_LAST = PRE_CNT_W'(PREAMBLE_FRAMES);

  logic [CHIP_ID_W-1:0] chip_id_r;
  logic                 seq_chk_r;
  logic [TIMEOUT_W-1:0] timeout_r;

  logic                 in_valid_r;
  logic [OP_W-1:0]      in_op_r;
  logic [MODE_W-1:0]    in_mode_r;
  logic [REF_W-1:0]     in_ref_r;
  logic [ADDR_W-1:0]    in_addr_r;
  logic [DATA_W-1:0]    in_data_r;
  logic [BITS_W-1:0]    in_bits_r;
  logic [RESP_W-1:0]    in_word_r;

  logic [PRE_CNT_W-1:0] pre_cnt_r;
  logic [SEQ_W-1:0]     seq_r;
  pend_t                pend_r;
  logic [ADDR_W-1:0]    exp_addr_r;
  logic [TIMEOUT_W-1:0] wait_r;

  logic [SEQ_W-1:0]     seq_nxt;
  pend_t                pend_nxt;
  logic [ADDR_W-1:0]    exp_addr_nxt;
  logic [TIMEOUT_W-1:0] wait_nxt;

  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [WORD_W-1:0]    out_word_r;
  logic [LEN_W-1:0]     out_len_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [DATA_W-1:0]    out_rdata_r;
  logic                 out_last_r;

  logic                 res_kind;
  logic [WORD_W-1:0]    res_word;
  logic [LEN_W-1:0]     res_len;
  status_t              res_status;
  logic [DATA_W-1:0]    res_rdata;
  logic                 res_last;

  logic                 produce;
  logic                 done;
  logic                 out_free;
  logic                 emit;
  logic                 take;
  logic                 accept_in;

  logic [BODY_W-1:0]    body;
  logic [REF_W-1:0]     efuse;
  logic [4:0]           pads;
  logic                 longr;
  logic [SEQ_W-1:0]     seq_adv;
  logic [SEQ_W-1:0]     rx_seq;
  logic [CHIP_ID_W-1:0] rx_id;
  logic [TIMEOUT_W-1:0] wait_inc;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign emit      = in_valid_r && produce && out_free;
  assign take      = in_valid_r && done && (!produce || out_free);
  assign in_ch.ready = !in_valid_r || take;
  assign accept_in = in_ch.valid && in_ch.ready;

  always_comb begin
    res_kind     = CFG_KIND_FRAME;
    res_word     = '0;
    res_len      = '0;
    res_status   = ST_OK;
    res_rdata    = '0;
    res_last     = 1'b1;
    produce      = 1'b0;
    done         = 1'b1;
    seq_nxt      = seq_r;
    pend_nxt     = pend_r;
    exp_addr_nxt = exp_addr_r;
    wait_nxt     = wait_r;
    body         = '0;
    efuse        = (in_mode_r == MODE_EFUSE) ? in_ref_r : REF_ONES;
    pads         = (in_mode_r == MODE_PADS) ? in_ref_r[4:0] : FILL5;
    longr        = (pend_r == PEND_READ) || (pend_r == PEND_READNEXT);
    seq_adv      = (pend_r == PEND_SETID) ? seq_r : seq_r + SEQ_W'(1);
    rx_seq       = longr ? in_word_r[42:40] : in_word_r[2:0];
    rx_id        = longr ? in_word_r[47:43] : in_word_r[7:3];
    wait_inc     = wait_r + TIMEOUT_W'(1);
    unique case (op_t'(in_op_r))
      OP_SETID: begin
        produce = 1'b1;
        if (pre_cnt_r != PRE_LAST) begin
          res_word = PREAMBLE_WORD;
          res_len  = LEN_PREAMBLE;
          res_last = 1'b0;
          done     = 1'b0;
        end else begin
          body     = {CMD_SETID, FILL5, FILL3, chip_id_r, FILL4, efuse, FILL3, pads};
          res_word = {body, crc8(body)};
          res_len  = LEN_LONG;
          seq_nxt  = seq_r + SEQ_W'(1);
          pend_nxt = PEND_SETID;
          wait_nxt = '0;
        end
      end
      OP_WRITE: begin
        produce  = 1'b1;
        body     = {CMD_WRITE, chip_id_r, in_addr_r, in_data_r};
        res_word = {body, crc8(body)};
        res_len  = LEN_LONG;
        pend_nxt = PEND_WRITE;
        wait_nxt = '0;
      end
      OP_READ: begin
        produce      = 1'b1;
        res_word     = WORD_W'({CMD_READ, chip_id_r, in_addr_r});
        res_len      = LEN_READ;
        exp_addr_nxt = in_addr_r;
        pend_nxt     = PEND_READ;
        wait_nxt     = '0;
      end
      OP_READNEXT: begin
        produce  = 1'b1;
        res_word = WORD_W'({CMD_READNEXT, chip_id_r});
        res_len  = LEN_READNEXT;
        pend_nxt = PEND_READNEXT;
        wait_nxt = '0;
      end
      OP_RESPONSE: begin
        produce  = 1'b1;
        res_kind = CFG_KIND_VERDICT;
        if (pend_r == PEND_NONE) begin
          res_status = ST_NOTHING_PENDING;
        end else begin
          seq_nxt  = seq_adv;
          pend_nxt = PEND_NONE;
          wait_nxt = '0;
          priority if (in_bits_r != (longr ? RESP_LONG_BITS : RESP_SHORT_BITS)) begin
            res_status = ST_BAD_LENGTH;
          end else if (pend_r == PEND_READ && in_word_r[39:32] != exp_addr_r) begin
            res_status = ST_BAD_ADDRESS;
          end else if (seq_chk_r && rx_seq != seq_adv) begin
            res_status = ST_BAD_SEQ;
          end else if (rx_id != chip_id_r) begin
            res_status = ST_BAD_ID;
          end else begin
            res_status = ST_OK;
            res_rdata  = longr ? in_word_r[DATA_W-1:0] : '0;
          end
        end
      end
      OP_TICK: begin
        if (pend_r != PEND_NONE) begin
          if (timeout_r == '0 || wait_inc >= timeout_r) begin
            produce    = 1'b1;
            res_kind   = CFG_KIND_VERDICT;
            res_status = ST_TIMEOUT;
            pend_nxt   = PEND_NONE;
            wait_nxt   = '0;
          end else begin
            wait_nxt = wait_inc;
          end
        end
      end
      OP_SEQ_RESET: begin
        seq_nxt  = '0;
        pend_nxt = PEND_NONE;
        wait_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_id_r <= '0;
      seq_chk_r <= 1'b0;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHIP_ID:   chip_id_r <= cfg_wdata[CHIP_ID_W-1:0];
        CFG_SEQ_CHECK: seq_chk_r <= cfg_wdata[0];
        CFG_TIMEOUT:   timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (accept_in) begin
      in_valid_r <= 1'b1;
    end else if (take) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      in_op_r   <= in_ch.operation;
      in_mode_r <= in_ch.id_mode;
      in_ref_r  <= in_ch.ref_id;
      in_addr_r <= in_ch.reg_address;
      in_data_r <= in_ch.write_value;
      in_bits_r <= in_ch.resp_bits;
      in_word_r <= in_ch.resp_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_cnt_r  <= '0;
      seq_r      <= '0;
      pend_r     <= PEND_NONE;
      exp_addr_r <= '0;
      wait_r     <= '0;
    end else begin
      if (take) begin
        pre_cnt_r  <= '0;
        seq_r      <= seq_nxt;
        pend_r     <= pend_nxt;
        exp_addr_r <= exp_addr_nxt;
        wait_r     <= wait_nxt;
      end else if (emit) begin
        pre_cnt_r <= pre_cnt_r + PRE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r   <= res_kind;
      out_word_r   <= res_word;
      out_len_r    <= res_len;
      out_status_r <= res_status;
      out_rdata_r  <= res_rdata;
      out_last_r   <= res_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.item_kind    = out_kind_r;
  assign out_ch.frame_word   = out_word_r;
  assign out_ch.frame_length = out_len_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.read_value   = out_rdata_r;
  assign out_ch.last         = out_last_r;

  `CCFC_ASSERT_SAME(a_preamble_holds_setid, clk, rst_n, pre_cnt_r != '0, in_valid_r && in_op_r == OP_SETID)
  `CCFC_ASSERT_NEXT(a_setid_leaves_pending, clk, rst_n, take && in_op_r == OP_SETID, pend_r == PEND_SETID)
  `CCFC_ASSERT_SAME(a_idle_wait_clear, clk, rst_n, pend_r == PEND_NONE, wait_r == '0)
  `CCFC_ASSERT_SAME(a_preamble_not_last, clk, rst_n, out_valid_r && out_kind_r == CFG_KIND_FRAME && out_len_r == LEN_PREAMBLE, !out_last_r)

endmodule

// File: test/tb_top.sv
// Self-checking testbench for chip_command_framer_checker: a table of directed
// transactions, then random command/reply traffic over several register settings.
// Depends on ccfc_pkg and the ccfc_in_if/ccfc_out_if interfaces from the design.
module tb_top import ccfc_pkg::*; ;

  localparam int LIMIT_CYCLES  = 100000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 28;

  typedef struct packed {
    op_t                operation;
    logic [MODE_W-1:0]  id_mode;
    logic [REF_W-1:0]   id_ref;
    logic [ADDR_W-1:0]  reg_address;
    logic [DATA_W-1:0]  write_value;
    logic [BITS_W-1:0]  resp_bits;
    logic [RESP_W-1:0]  resp_word;
  } link_item_t;

  typedef struct packed {
    logic                kind;
    logic [WORD_W-1:0]   word;
    logic [LEN_W-1:0]    len;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   rdata;
    logic                last;
  } link_result_t;

  typedef struct {
    bit           is_cfg;
    link_item_t   item;
    bit           typed;
    link_result_t want;
  } plan_row_t;

  typedef struct {
    int chip;
    int seq_en;
    int tmo;
    int sidle;
    int rstall;
    bit press;
  } phase_t;

  localparam link_result_t NO_RESULT = '0;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ccfc_in_if  in_ch ();
  ccfc_out_if out_ch ();

  chip_command_framer_checker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block's registers and state
  logic [CHIP_ID_W-1:0] chip_id_m  = '0;
  logic                 seq_chk_m  = 1'b0;
  logic [TIMEOUT_W-1:0] tmo_m      = TIMEOUT_RESET;
  logic [SEQ_W-1:0]     seq_ctr    = '0;
  pend_t                pend       = PEND_NONE;
  logic [ADDR_W-1:0]    exp_addr   = '0;
  logic [TIMEOUT_W-1:0] wait_cnt   = '0;

  link_result_t step_results[$];
  link_result_t link_results_due[$];

  int errors      = 0;
  int cycles      = 0;
  int send_idle   = 0;
  int rcv_stall   = 0;
  int hold_ticket = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  plan_row_t plan [24] = '{
    '{1'b0, '{OP_RESPONSE, 2'd0, 20'd0, 8'd0, 32'd0, 6'd63, 48'hFFFF_FFFF_FFFF}, 1'b1,
      '{CFG_KIND_VERDICT, 56'd0, 6'd0, ST_NOTHING_PENDING, 32'd0, 1'b1}},
    '{1'b0, '{OP_TICK, 2'd0, 20'd0, 8'd0, 32'd0, 6'd0, 48'd0}, 1'b0, NO_RESULT},
    '{1'b0, '{OP_READNEXT, 2'd0, 20'd0, 8'd0, 32'd0, 6'd0, 48'd0}, 1'b1,
      '{CFG_KIND_FRAME, 56'h80, LEN_READNEXT, ST_OK, 32'd0, 1'b1}},
    '{1'b0, '{OP_RESPONSE, 2'd0, 20'd0, 8'd0, 32'd0, 6'd48, 48'h0000_FFFF_FFFF}, 1'b1,
      '{CFG_KIND_VERDICT, 56'd0, 6'd0, ST_OK, 32'hFFFF_FFFF, 1'b1}},
    '{1'b0, '{OP_READ, 2'd0, 20'd0, 8'hFF, 32'd0, 6'd0, 48'd0}, 1'b1,
      '{CFG_KIND_FRAME, 56'hA0FF, LEN_READ, ST_OK, 32'd0, 1'b1}},
    '{1'b0, '{OP_RESPONSE, 2'd0, 20'd0, 8'd0, 32'd0, 6'd48, 48'h0000_1234_5678}, 1'b1,
      '{CFG_KIND_VERDICT, 56'd0, 6'd0, ST_BAD_ADDRESS, 32'd0, 1'b1}},
    '{1'b0, '{OP_WRITE, 2'd0, 20'd0, 8'hFF, 32'hFFFF_FFFF, 6'd0, 48'd0}, 1'b0, NO_RESULT},
    '{1'b0, '{OP_RESPONSE, 2'd0, 20'd0, 8'd0, 32'd0, 6'd7, 48'd0}, 1'b1,
      '{CFG_KIND_VERDICT, 56'd0, 6'd0, ST_BAD_LENGTH, 32'd0, 1'b1}},
    '{1'b0, '{OP_SETID, MODE_EFUSE, 20'hFFFFF, 8'd0, 32'd0, 6'd0, 48'd0}, 1'b0, NO_RESULT},
    '{1'b0, '{OP_RESPONSE, 2'd0, 20'd0, 8'd0, 32'd0, 6'd8, 48'hF8}, 1'b1,
      '{CFG_KIND_VERDICT, 56'd0, 6'd0, ST_BAD_ID, 32'd0, 1'b1}},
    '{1'b0, '{OP_WRITE, 2'd0, 20'd0, 8'd0, 32'd0, 6'd0, 48'd0}, 1'b0, NO_RESULT},
    '{1'b0, '{OP_SEQ_RESET, 2'd0, 20'd0, 8'd0, 32'd0, 6'd0, 48'd0}, 1'b0, NO_RESULT},
    '{1'b0, '{OP_NONE, 2'd3, 20'hFFFFF, 8'hFF, 32'hFFFF_FFFF, 6'd63, 48'hFFFF_FFFF_FFFF},
      1'b0, NO_RESULT},
    '{1'b0, '{OP_RESPONSE, 2'd0, 20'd0, 8'd0, 32'd0, 6'd8, 48'd0}, 1'b1,
      '{CFG_KIND_VERDICT, 56'd0, 6'd0, ST_NOTHING_PENDING, 32'd0, 1'b1}},
    '{1'b1, '{OP_NONE, 2'd0, 20'd0, 8'(CFG_CHIP_ID), 32'd31, 6'd0, 48'd0}, 1'b0, NO_RESULT},
    '{1'b1, '{OP_NONE, 2'd0, 20'd0, 8'(CFG_SEQ_CHECK), 32'd1, 6'd0, 48'd0}, 1'b0, NO_RESULT},
    '{1'b1, '{OP_NONE, 2'd0, 20'd0, 8'(CFG_TIMEOUT), 32'd1, 6'd0, 48'd0}, 1'b0, NO_RESULT},
    '{1'b0, '{OP_SETID, MODE_PADS, 20'hABCDF, 8'd0, 32'd0, 6'd0, 48'd0}, 1'b0, NO_RESULT},
    '{1'b0, '{OP_TICK, 2'd0, 20'd0, 8'd0, 32'd0, 6'd0, 48'd0}, 1'b1,
      '{CFG_KIND_VERDICT, 56'd0, 6'd0, ST_TIMEOUT, 32'd0, 1'b1}},
    '{1'b0, '{OP_SETID, 2'd2, 20'd0, 8'd0, 32'd0, 6'd0, 48'd0}, 1'b0, NO_RESULT},
    '{1'b0, '{OP_SETID, 2'd3, 20'h12345, 8'd0, 32'd0, 6'd0, 48'd0}, 1'b0, NO_RESULT},
    '{1'b0, '{OP_READ, 2'd0, 20'd0, 8'h5A, 32'd0, 6'd0, 48'd0}, 1'b1,
      '{CFG_KIND_FRAME, 56'hBF5A, LEN_READ, ST_OK, 32'd0, 1'b1}},
    '{1'b0, '{OP_READNEXT, 2'd0, 20'd0, 8'd0, 32'd0, 6'd0, 48'd0}, 1'b1,
      '{CFG_KIND_FRAME, 56'h9F, LEN_READNEXT, ST_OK, 32'd0, 1'b1}},
    '{1'b0, '{OP_RESPONSE, 2'd0, 20'd0, 8'd0, 32'd0, 6'd48, 48'hF800_0000_0000}, 1'b1,
      '{CFG_KIND_VERDICT, 56'd0, 6'd0, ST_BAD_SEQ, 32'd0, 1'b1}}
  };

  phase_t phases [5] = '{
    '{5,  1, 3,    0,  0,  1'b0},
    '{31, 1, 1,    51, 0,  1'b0},
    '{0,  0, 1023, 0,  51, 1'b0},
    '{17, 1, 7,    30, 30, 1'b0},
    '{10, 0, 2,    0,  0,  1'b1}
  };

  function automatic logic [CRC_W-1:0] xor_bytes(input logic [BODY_W-1:0] body);
    logic [CRC_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < BODY_W; i += CRC_W) acc ^= body[i +: CRC_W];
    return acc;
  endfunction

  function automatic void predict_link(input link_item_t it);
    logic [BODY_W-1:0]    body;
    logic [SEQ_W-1:0]     sq;
    logic [CHIP_ID_W-1:0] id;
    logic [STATUS_W-1:0]  st;
    logic [DATA_W-1:0]    rd;
    logic                 longr;
    step_results.delete();
    case (it.operation)
      OP_SETID: begin
        repeat (PREAMBLE_FRAMES_DEF)
          step_results.push_back(link_result_t'{CFG_KIND_FRAME, PREAMBLE_WORD, LEN_PREAMBLE,
                                                ST_OK, 32'd0, 1'b0});
        body = {CMD_SETID, FILL5, FILL3, chip_id_m, FILL4,
                (it.id_mode == MODE_EFUSE) ? it.id_ref : REF_ONES, FILL3,
                (it.id_mode == MODE_PADS) ? it.id_ref[4:0] : FILL5};
        step_results.push_back(link_result_t'{CFG_KIND_FRAME, {body, xor_bytes(body)},
                                              LEN_LONG, ST_OK, 32'd0, 1'b1});
        seq_ctr++;
        pend = PEND_SETID;
        wait_cnt = '0;
      end
      OP_WRITE: begin
        body = {CMD_WRITE, chip_id_m, it.reg_address, it.write_value};
        step_results.push_back(link_result_t'{CFG_KIND_FRAME, {body, xor_bytes(body)},
                                              LEN_LONG, ST_OK, 32'd0, 1'b1});
        pend = PEND_WRITE;
        wait_cnt = '0;
      end
      OP_READ: begin
        step_results.push_back(link_result_t'{CFG_KIND_FRAME,
                                              56'({CMD_READ, chip_id_m, it.reg_address}),
                                              LEN_READ, ST_OK, 32'd0, 1'b1});
        exp_addr = it.reg_address;
        pend = PEND_READ;
        wait_cnt = '0;
      end
      OP_READNEXT: begin
        step_results.push_back(link_result_t'{CFG_KIND_FRAME, 56'({CMD_READNEXT, chip_id_m}),
                                              LEN_READNEXT, ST_OK, 32'd0, 1'b1});
        pend = PEND_READNEXT;
        wait_cnt = '0;
      end
      OP_RESPONSE: begin
        st = ST_NOTHING_PENDING;
        rd = '0;
        if (pend != PEND_NONE) begin
          longr = (pend == PEND_READ) || (pend == PEND_READNEXT);
          if (pend != PEND_SETID) seq_ctr++;
          sq = longr ? it.resp_word[42:40] : it.resp_word[2:0];
          id = longr ? it.resp_word[47:43] : it.resp_word[7:3];
          if (it.resp_bits != (longr ? RESP_LONG_BITS : RESP_SHORT_BITS)) st = ST_BAD_LENGTH;
          else if (pend == PEND_READ && it.resp_word[39:32] != exp_addr) st = ST_BAD_ADDRESS;
          else if (seq_chk_m && sq != seq_ctr) st = ST_BAD_SEQ;
          else if (id != chip_id_m) st = ST_BAD_ID;
          else st = ST_OK;
          if (st == ST_OK && longr) rd = it.resp_word[31:0];
          pend = PEND_NONE;
          wait_cnt = '0;
        end
        step_results.push_back(link_result_t'{CFG_KIND_VERDICT, 56'd0, 6'd0, st, rd, 1'b1});
      end
      OP_TICK: begin
        if (pend != PEND_NONE) begin
          wait_cnt++;
          if (tmo_m == '0 || wait_cnt >= tmo_m) begin
            pend = PEND_NONE;
            wait_cnt = '0;
            step_results.push_back(link_result_t'{CFG_KIND_VERDICT, 56'd0, 6'd0, ST_TIMEOUT,
                                                  32'd0, 1'b1});
          end
        end
      end
      OP_SEQ_RESET: begin
        seq_ctr = '0;
        pend = PEND_NONE;
        wait_cnt = '0;
      end
      default: ;
    endcase
  endfunction

  // mostly well-formed exchanges: command, some ticks, matching reply
  function automatic link_item_t pick_item();
    link_item_t it;
    int r;
    logic [SEQ_W-1:0] sq;
    logic longr;
    it.operation   = op_t'($urandom_range(7));
    it.id_mode     = 2'($urandom_range(3));
    it.id_ref      = 20'($urandom);
    it.reg_address = 8'($urandom);
    it.write_value = $urandom;
    it.resp_bits   = 6'($urandom);
    it.resp_word   = 48'({$urandom, $urandom});
    r = $urandom_range(99);
    if (pend != PEND_NONE) begin
      if (r < 60) begin
        it.operation = OP_RESPONSE;
        longr = (pend == PEND_READ) || (pend == PEND_READNEXT);
        sq = (pend == PEND_SETID) ? seq_ctr : seq_ctr + 3'd1;
        if (longr) begin
          it.resp_bits = RESP_LONG_BITS;
          it.resp_word[47:40] = {chip_id_m, sq};
          if (pend == PEND_READ) it.resp_word[39:32] = exp_addr;
        end else begin
          it.resp_bits = RESP_SHORT_BITS;
          it.resp_word[7:0] = {chip_id_m, sq};
        end
        case ($urandom_range(7))
          0: it.resp_bits = 6'($urandom);
          1: it.resp_word ^= 48'd1 << (longr ? $urandom_range(32, 47) : $urandom_range(0, 7));
          default: ;
        endcase
      end else if (r < 85) begin
        it.operation = OP_TICK;
      end else if (r < 93) begin
        it.operation = op_t'($urandom_range(3));
      end else if (r < 97) begin
        it.operation = OP_SEQ_RESET;
      end
    end else begin
      if (r < 70) it.operation = ($urandom_range(7) == 0) ? OP_SETID : op_t'($urandom_range(1, 3));
      else if (r < 85) it.operation = OP_RESPONSE;
      else if (r < 92) it.operation = OP_TICK;
    end
    return it;
  endfunction

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (link_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CHIP_ID:   chip_id_m = val[CHIP_ID_W-1:0];
      CFG_SEQ_CHECK: seq_chk_m = val[0];
      CFG_TIMEOUT:   tmo_m = val[TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_item(input link_item_t it, input bit typed, input link_result_t want);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_ch.operation   <= it.operation;
    in_ch.id_mode     <= it.id_mode;
    in_ch.ref_id      <= it.id_ref;
    in_ch.reg_address <= it.reg_address;
    in_ch.write_value <= it.write_value;
    in_ch.resp_bits   <= it.resp_bits;
    in_ch.resp_word   <= it.resp_word;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_link(it);
    if (typed) link_results_due.push_back(want);
    else foreach (step_results[i]) link_results_due.push_back(step_results[i]);
  endtask

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    link_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (link_results_due.size() == 0) begin
        $error("result with nothing expected: kind %0h word %0h status %0h",
               out_ch.item_kind, out_ch.frame_word, out_ch.status);
        errors++;
      end else begin
        want = link_results_due.pop_front();
        compare_field("item_kind", 64'(want.kind), 64'(out_ch.item_kind));
        compare_field("frame_word", 64'(want.word), 64'(out_ch.frame_word));
        compare_field("frame_length", 64'(want.len), 64'(out_ch.frame_length));
        compare_field("status", 64'(want.status), 64'(out_ch.status));
        compare_field("read_value", 64'(want.rdata), 64'(out_ch.read_value));
        compare_field("last", 64'(want.last), 64'(out_ch.last));
      end
    end
  end

  initial begin : receiver
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    link_item_t it;
    int count;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= '0;
    in_ch.id_mode     <= '0;
    in_ch.ref_id      <= '0;
    in_ch.reg_address <= '0;
    in_ch.write_value <= '0;
    in_ch.resp_bits   <= '0;
    in_ch.resp_word   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        cfg_write(plan[i].item.reg_address[CFG_IDX_W-1:0],
                  plan[i].item.write_value[CFG_DATA_W-1:0]);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    foreach (phases[p]) begin
      cfg_write(CFG_CHIP_ID, CFG_DATA_W'(phases[p].chip));
      cfg_write(CFG_SEQ_CHECK, CFG_DATA_W'(phases[p].seq_en));
      cfg_write(CFG_TIMEOUT, CFG_DATA_W'(phases[p].tmo));
      send_idle = phases[p].sidle;
      rcv_stall <= phases[p].rstall;
      if (phases[p].press) hold_ticket <= hold_ticket + 1;
      count = 0;
      while (count < PHASE_ITEMS) begin
        it = pick_item();
        if (!(it.operation == OP_NONE || (it.operation == OP_TICK && pend == PEND_NONE)))
          count++;
        send_item(it, 1'b0, NO_RESULT);
        // pause the sender until the block drains
        if (phases[p].press && count == PHASE_ITEMS / 2) settle();
      end
    end

    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
